[hw/rtl/ffpe_pkg.sv]
// ----------------------------------------------------------------------------
// ffpe_pkg
// Shared constants for the flow field predicate evaluator.
// ----------------------------------------------------------------------------
`default_nettype none
package ffpe_pkg;
    localparam int LABEL_DEPTH_DEF = 10;
    localparam int ADDR_W          = 6;
    localparam int DATA_W          = 64;

    localparam logic [ADDR_W-1:0] A_OPER   = 6'd0;
    localparam logic [ADDR_W-1:0] A_VALUE  = 6'd8;
    localparam logic [ADDR_W-1:0] A_IP_HI  = 6'd16;
    localparam logic [ADDR_W-1:0] A_IP_LO  = 6'd24;
    localparam logic [ADDR_W-1:0] A_MK_HI  = 6'd32;
    localparam logic [ADDR_W-1:0] A_MK_LO  = 6'd40;
    localparam logic [ADDR_W-1:0] A_IPVER  = 6'd48;
    localparam logic [ADDR_W-1:0] A_LBLIDX = 6'd56;

    localparam logic [1:0] V_NO  = 2'd0;
    localparam logic [1:0] V_YES = 2'd1;
    localparam logic [1:0] V_ERR = 2'd2;

    localparam logic [6:0] OP_SGN   = 7'd30;
    localparam logic [6:0] OP_DBL   = 7'd48;
    localparam logic [6:0] OP_MAC   = 7'd51;
    localparam logic [6:0] OP_IP4   = 7'd52;
    localparam logic [6:0] OP_IP6   = 7'd53;
    localparam logic [6:0] OP_PFX   = 7'd54;
    localparam logic [6:0] OP_ANY   = 7'd55;
    localparam logic [6:0] OP_LBL   = 7'd58;
    localparam logic [6:0] OP_EXP   = 7'd61;
    localparam logic [6:0] OP_DEPTH = 7'd66;
    localparam logic [6:0] OP_END   = 7'd69;
endpackage
`default_nettype wire

[hw/rtl/flow_field_predicate_eval.sv]
// ----------------------------------------------------------------------------
// flow_field_predicate_eval
// Tests one flow-record field per transfer against a configured predicate.
// Pipeline: the input transfer is captured in the input reg, then the verdict in the result reg.
// Throughput: one record per cycle; the result register stalls only when
// the downstream side holds tready low.
// Reset: synchronous active low; config registers return to defaults, ip_version 4,
// label_index 1, pipeline empty.
// ----------------------------------------------------------------------------
`default_nettype none
module flow_field_predicate_eval #(
    parameter int LABEL_DEPTH = ffpe_pkg::LABEL_DEPTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    // field_size[4:0], rec_word0[68:5], rec_word1[132:69],
    // rec_word2[196:133], rec_word3[260:197], zero fill
    input  wire logic [263:0]                  s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // verdict[1:0], zero fill
    output logic [7:0]                         m_axis_tdata,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [ffpe_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [ffpe_pkg::DATA_W-1:0]   pwdata,
    output logic [ffpe_pkg::DATA_W-1:0]        prdata,
    output logic                               pready
);
    import ffpe_pkg::*;

    localparam int LIDX_W = 5;

    logic [6:0]  r_oper;
    logic [63:0] r_value, r_ip_hi, r_ip_lo, r_mk_hi, r_mk_lo;
    logic [2:0]  r_ipver;
    logic [3:0]  r_lidx;

    logic        r_v1;
    logic [4:0]  r_size;
    logic [63:0] r_w0, r_w1, r_w2, r_w3;
    logic        r_v2;
    logic [1:0]  r_verdict;
    logic [1:0]  n_verdict;
    logic        adv2, adv1, wr;

    assign pready = 1'b1;
    assign wr     = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oper <= '0; r_value <= '0; r_ip_hi <= '0; r_ip_lo <= '0;
            r_mk_hi <= '0; r_mk_lo <= '0; r_ipver <= 3'd4; r_lidx <= 4'd1;
        end else if (wr) begin
            unique case (paddr)
                A_OPER:   r_oper  <= pwdata[6:0];
                A_VALUE:  r_value <= pwdata;
                A_IP_HI:  r_ip_hi <= pwdata;
                A_IP_LO:  r_ip_lo <= pwdata;
                A_MK_HI:  r_mk_hi <= pwdata;
                A_MK_LO:  r_mk_lo <= pwdata;
                A_IPVER:  r_ipver <= pwdata[2:0];
                A_LBLIDX: r_lidx  <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr)
            A_OPER:   prdata = {57'd0, r_oper};
            A_VALUE:  prdata = r_value;
            A_IP_HI:  prdata = r_ip_hi;
            A_IP_LO:  prdata = r_ip_lo;
            A_MK_HI:  prdata = r_mk_hi;
            A_MK_LO:  prdata = r_mk_lo;
            A_IPVER:  prdata = {61'd0, r_ipver};
            A_LBLIDX: prdata = {60'd0, r_lidx};
            default:  prdata = '0;
        endcase
    end

    assign adv2          = !r_v2 || m_axis_tready;
    assign adv1          = !r_v1 || adv2;
    assign s_axis_tready = adv1;
    assign m_axis_tvalid = r_v2;
    assign m_axis_tdata  = {6'd0, r_verdict};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (adv1) r_v1 <= s_axis_tvalid;
            if (adv2) r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1 && s_axis_tvalid) begin
            r_size <= s_axis_tdata[4:0];
            r_w0   <= s_axis_tdata[68:5];
            r_w1   <= s_axis_tdata[132:69];
            r_w2   <= s_axis_tdata[196:133];
            r_w3   <= s_axis_tdata[260:197];
        end
        if (adv2 && r_v1) r_verdict <= n_verdict;
    end

    // ---- integer fetch ----
    function automatic logic [63:0] bswap(input logic [63:0] w, input logic [3:0] n);
        logic [63:0] r;
        r = '0;
        for (int i = 0; i < 8; i++)
            if (i < n) r = {r[55:0], w[8*i +: 8]};
        return r;
    endfunction

    function automatic logic [1:0] cmp3(input logic [1:0] op, input logic eq,
                                        input logic gt, input logic lt);
        logic h;
        h = (op == 2'd0) ? eq : (op == 2'd1) ? gt : lt;
        return h ? V_YES : V_NO;
    endfunction

    logic [255:0] stk;
    logic [23:0]  ent [LABEL_DEPTH];
    assign stk = {r_w3, r_w2, r_w1, r_w0};

    for (genvar k = 0; k < LABEL_DEPTH; k++) begin : g_ent
        if (24*k + 24 <= 256) begin : g_full
            assign ent[k] = stk[24*k +: 24];
        end else if (24*k < 256) begin : g_part
            assign ent[k] = {{(24*k+24-256){1'b0}}, stk[255:24*k]};
        end else begin : g_none
            assign ent[k] = '0;
        end
    end

    always_comb begin
        logic [6:0]  code;
        logic [2:0]  t;
        logic [2:0]  op;
        logic [3:0]  n;
        logic        okv, sgn;
        logic [63:0] v, a, b, m;
        logic [63:0] rv;
        logic        dn_d, dn_r, fe, fgt, flt, fz;
        logic [31:0] rw0, rw1, rw2, rw3, mw3;
        logic        hiz, pres, hit, stop;
        logic [LIDX_W-1:0] dep;
        logic [23:0] e;
        logic [19:0] lbl;
        logic [2:0]  ex;

        code = r_oper;
        rv   = r_value;
        n_verdict = V_ERR;
        t = '0; op = '0; sgn = 1'b0; v = '0; a = '0; b = '0; m = '0; okv = 1'b1;
        n = 4'd8;
        dn_d = 1'b0; dn_r = 1'b0; fe = 1'b0; fgt = 1'b0; flt = 1'b0; fz = 1'b0;
        rw0 = '0; rw1 = '0; rw2 = '0; rw3 = '0; mw3 = '0;
        hiz = 1'b0; pres = 1'b0; hit = 1'b0; stop = 1'b0;
        dep = '0; lbl = '0; ex = '0;
        e = ent[0];
        if (code < OP_DBL) begin
            sgn = code >= OP_SGN;
            if (sgn) begin
                for (int k = 0; k < 6; k++)
                    if (code >= OP_SGN + 7'(3 * k)) begin
                        t  = 3'(k);
                        op = 3'(code - OP_SGN - 7'(3 * k));
                    end
            end else begin
                for (int k = 0; k < 6; k++)
                    if (code >= 7'(5 * k)) begin
                        t  = 3'(k);
                        op = 3'(code - 7'(5 * k));
                    end
            end
            if (t <= 3'd1) begin
                unique case (r_size)
                    5'd1: n = 4'd1;
                    5'd2: n = 4'd2;
                    5'd4: n = 4'd4;
                    5'd8: n = 4'd8;
                    default: begin n = 4'd8; okv = 1'b0; end
                endcase
                if (t == 3'd0) begin
                    m = (n == 4'd8) ? '1 : ((64'd1 << {n, 3'd0}) - 64'd1);
                    v = r_w0 & m;
                end else begin
                    v = bswap(r_w0, n);
                end
            end else begin
                n = (t == 3'd2) ? 4'd8 : (t == 3'd3) ? 4'd4 : (t == 3'd4) ? 4'd2 : 4'd1;
                unique case (n)
                    4'd8: v = r_w0;
                    4'd4: v = sgn ? {{32{r_w0[31]}}, r_w0[31:0]} : {32'd0, r_w0[31:0]};
                    4'd2: v = sgn ? {{48{r_w0[15]}}, r_w0[15:0]} : {48'd0, r_w0[15:0]};
                    default: v = sgn ? {{56{r_w0[7]}}, r_w0[7:0]} : {56'd0, r_w0[7:0]};
                endcase
            end
            a = sgn ? {~v[63], v[62:0]} : v;
            b = sgn ? {~rv[63], rv[62:0]} : rv;
            if (!okv) n_verdict = V_ERR;
            else if (op < 3'd3) n_verdict = cmp3(op[1:0], a == b, a > b, a < b);
            else if (op == 3'd3) n_verdict = ((v & rv) == rv) ? V_YES : V_NO;
            else n_verdict = ((v & rv) == 64'd0) ? V_YES : V_NO;
        end else if (code < OP_MAC) begin
            dn_d = (r_w0[62:52] == 11'h7FF) && (r_w0[51:0] != 0);
            dn_r = (rv[62:52] == 11'h7FF) && (rv[51:0] != 0);
            fz   = (r_w0[62:0] == 0) && (rv[62:0] == 0);
            fe   = !dn_d && !dn_r && (fz || r_w0 == rv);
            if (dn_d || dn_r || fe) begin
                fgt = 1'b0;
                flt = 1'b0;
            end else if (r_w0[63] != rv[63]) begin
                fgt = !r_w0[63];
                flt = r_w0[63];
            end else begin
                fgt = r_w0[63] ? (r_w0[62:0] < rv[62:0]) : (r_w0[62:0] > rv[62:0]);
                flt = !fgt;
            end
            n_verdict = cmp3(2'(code - OP_DBL), fe, fgt, flt);
        end else if (code == OP_MAC) begin
            n_verdict = (r_w0[47:0] == rv[47:0]) ? V_YES : V_NO;
        end else if (code < OP_ANY) begin
            rw0 = r_w0[63:32]; rw1 = r_w0[31:0]; rw2 = r_w1[63:32]; rw3 = r_w1[31:0];
            mw3 = r_mk_lo[31:0];
            hiz = (rw0 == 0) && (rw1 == 0) && (rw2 == 0);
            if (code == OP_IP4) begin
                if (r_size == 5'd4) n_verdict = (rw1 == r_ip_lo[31:0]) ? V_YES : V_NO;
                else n_verdict = (hiz && rw3 == r_ip_lo[31:0]) ? V_YES : V_NO;
            end else if (code == OP_IP6) begin
                if (r_size == 5'd4) n_verdict = V_NO;
                else n_verdict = (r_w0 == r_ip_hi && r_w1 == r_ip_lo) ? V_YES : V_NO;
            end else if (r_size == 5'd4) begin
                if (r_ipver == 3'd6) n_verdict = V_NO;
                else n_verdict = ((rw1 & mw3) == r_ip_lo[31:0]) ? V_YES : V_NO;
            end else if (r_ipver == 3'd6 && hiz) begin
                n_verdict = V_NO;
            end else begin
                pres = ((r_w0 & r_mk_hi) == r_ip_hi) && ((r_w1 & r_mk_lo) == r_ip_lo);
                if (pres && r_ipver == 3'd4 && !hiz) n_verdict = V_NO;
                else n_verdict = pres ? V_YES : V_NO;
            end
        end else if (code >= OP_END) begin
            n_verdict = V_ERR;
        end else if (code < OP_LBL) begin
            hit = 1'b0; stop = 1'b0;
            for (int x = 0; x < LABEL_DEPTH; x++) begin
                if (!stop) begin
                    lbl = ent[x][19:0];
                    unique case (2'(code - OP_ANY))
                        2'd0: hit = rv == {44'd0, lbl};
                        2'd1: hit = rv < {44'd0, lbl};
                        default: hit = rv > {44'd0, lbl};
                    endcase
                    stop = hit || ent[x][23];
                end
            end
            n_verdict = hit ? V_YES : V_NO;
        end else if (code < OP_DEPTH) begin
            if (r_lidx == 4'd0 || 32'(r_lidx) > LABEL_DEPTH) begin
                n_verdict = V_ERR;
            end else begin
                for (int x = 0; x < LABEL_DEPTH; x++)
                    if (32'(r_lidx) == x + 1) e = ent[x];
                lbl = e[19:0];
                ex  = e[22:20];
                if (code < OP_EXP) begin
                    n_verdict = cmp3(2'(code - OP_LBL), rv == {44'd0, lbl},
                                     {44'd0, lbl} > rv, {44'd0, lbl} < rv);
                end else begin
                    op = 3'(code - OP_EXP);
                    if (op < 3'd3)
                        n_verdict = cmp3(op[1:0], rv == {61'd0, ex},
                                         {61'd0, ex} > rv, {61'd0, ex} < rv);
                    else if (op == 3'd3)
                        n_verdict = ((rv & {61'd0, ex}) == rv) ? V_YES : V_NO;
                    else
                        n_verdict = ((rv & {61'd0, ex}) == 64'd0) ? V_YES : V_NO;
                end
            end
        end else begin
            dep = LIDX_W'(LABEL_DEPTH + 1);
            for (int x = LABEL_DEPTH - 1; x >= 0; x--)
                if (ent[x][23]) dep = LIDX_W'(x + 1);
            n_verdict = cmp3(2'(code - OP_DEPTH), rv == 64'(dep),
                             64'(dep) > rv, 64'(dep) < rv);
        end
    end
endmodule
`default_nettype wire
